// ----- rtl/ctsi_pkg.sv -----
// shared types, constants and output stage functions for the colour temperature spline block
// no dependencies
`default_nettype none

package ctsi_pkg;

    localparam int TABLE_ROWS_DEF        = 512;
    localparam int KELVIN_STEP_DEF       = 100;
    localparam int KELVIN_BASE_STEPS_DEF = 10;

    localparam int NCHAN  = 7;
    localparam int NSTAGE = 16;

    localparam int Y_W    = 32;
    localparam int D_W    = 33;
    localparam int M_W    = 34;
    localparam int C_W    = 37;
    localparam int ACC_W  = 40;
    localparam int U_W    = 17;
    localparam int PROD_W = ACC_W + U_W;
    localparam int TOT_W  = PROD_W + 1;
    localparam int P_W    = 41;

    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_QUERY = 1'b1
    } t_opcode;

    typedef enum logic [1:0] {
        ST_IN_RANGE = 2'd0,
        ST_UNDER    = 2'd1,
        ST_OVER     = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        CH_INTENSITY = 3'd0,
        CH_NORM_R    = 3'd1,
        CH_NORM_G    = 3'd2,
        CH_NORM_B    = 3'd3,
        CH_BYTE_R    = 3'd4,
        CH_BYTE_G    = 3'd5,
        CH_BYTE_B    = 3'd6
    } t_channel;

    typedef struct packed {
        t_status     status;
        logic [15:0] used;
    } t_meta;

    typedef struct packed {
        logic first;
        logic m1_end;
        logic direct;
    } t_seg;

    typedef struct packed {
        logic [1:0] rot;
        t_seg       seg;
    } t_lane_ctl;

    function automatic logic [31:0] sat_int(input logic signed [P_W-1:0] p);
        logic [31:0] res;
        if (p > P_W'(64'sd2147483647)) begin
            res = 32'h7fff_ffff;
        end else if (p < -P_W'(64'sd2147483648)) begin
            res = 32'h8000_0000;
        end else begin
            res = p[31:0];
        end
        return res;
    endfunction

    function automatic logic [16:0] clamp_norm(input logic signed [P_W-1:0] p);
        logic [16:0] res;
        if (p < P_W'(0)) begin
            res = 17'd0;
        end else if (p > P_W'(65536)) begin
            res = 17'd65536;
        end else begin
            res = p[16:0];
        end
        return res;
    endfunction

    function automatic logic [7:0] to_byte(input logic signed [P_W-1:0] p);
        logic [23:0] c;
        logic [7:0]  ip;
        logic [15:0] fr;
        logic        rnd;
        if (p < P_W'(0)) begin
            c = 24'd0;
        end else if (p > P_W'(255 * 65536)) begin
            c = 24'(255 * 65536);
        end else begin
            c = p[23:0];
        end
        ip  = c[23:16];
        fr  = c[15:0];
        rnd = (fr > 16'h8000) || ((fr == 16'h8000) && ip[0]);
        return ip + 8'(rnd);
    endfunction

endpackage

`default_nettype wire

// ----- rtl/ctsi_in_if.sv -----
// input channel: load and query transactions
// depends on nothing
`default_nettype none

interface ctsi_in_if;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic [8:0]  entry_index;
    logic [2:0]  channel;
    logic [31:0] value;
    logic [15:0] kelvin;

    modport source (output valid, opcode, entry_index, channel, value, kelvin, input ready);
    modport sink   (input valid, opcode, entry_index, channel, value, kelvin, output ready);
endinterface

`default_nettype wire

// ----- rtl/ctsi_out_if.sv -----
// output channel: one result transaction per query
// depends on nothing
`default_nettype none

interface ctsi_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [15:0] kelvin_used;
    logic [31:0] intensity;
    logic [16:0] lvl_red;
    logic [16:0] lvl_green;
    logic [16:0] lvl_blue;
    logic [7:0]  pwm_red;
    logic [7:0]  pwm_green;
    logic [7:0]  pwm_blue;

    modport source (output valid, status, kelvin_used, intensity, lvl_red, lvl_green,
                    lvl_blue, pwm_red, pwm_green, pwm_blue, input ready);
    modport sink   (input valid, status, kelvin_used, intensity, lvl_red, lvl_green,
                    lvl_blue, pwm_red, pwm_green, pwm_blue, output ready);
endinterface

`default_nettype wire

// ----- rtl/ctsi_ram.sv -----
// generic simple dual-port ram, one write and one registered read port
// no dependencies
`default_nettype none

module ctsi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                       i_wdata,
    input  wire logic                                   i_re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/ctsi_locate.sv -----
// segment locator: kelvin to row n and fraction u by reciprocal multiply and correction
// depends on ctsi_pkg
`default_nettype none

module ctsi_locate #(
    parameter int TABLE_ROWS        = ctsi_pkg::TABLE_ROWS_DEF,
    parameter int KELVIN_STEP       = ctsi_pkg::KELVIN_STEP_DEF,
    parameter int KELVIN_BASE_STEPS = ctsi_pkg::KELVIN_BASE_STEPS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic [6:0]                    i_en,
    input  wire logic [15:0]                   i_kelvin,
    output ctsi_pkg::t_meta                    o_meta,
    output logic [$clog2(TABLE_ROWS)-1:0]      o_n,
    output ctsi_pkg::t_seg                     o_seg,
    output logic [15:0]                        o_u
);

    localparam int RW   = $clog2(TABLE_ROWS);
    localparam int LO   = KELVIN_BASE_STEPS * KELVIN_STEP;
    localparam int HI   = (KELVIN_BASE_STEPS + TABLE_ROWS - 1) * KELVIN_STEP;
    localparam int SW   = $clog2(KELVIN_STEP + 1);
    localparam int QM_W = 17 + SW;
    localparam int PU_W = SW + 33;
    localparam int UM_W = 16 + SW;
    localparam logic [32:0]   RECIP  = 33'(64'h1_0000_0000 / 64'(KELVIN_STEP));
    localparam logic [SW-1:0] STEP_V = SW'(KELVIN_STEP);

    // stage 2
    logic [31:0]     w_k32;
    logic            w_under, w_over;
    ctsi_pkg::t_meta n_meta;
    logic [15:0]     r_off2;
    logic            r_under2, r_over2;
    // stage 3
    logic [48:0]     r_prod3;
    logic [15:0]     r_off3;
    logic            r_under3, r_over3;
    // stage 4
    logic [16:0]     r_q4;
    logic [QM_W-1:0] r_qm4;
    logic [15:0]     r_off4;
    logic            r_under4, r_over4;
    // stage 5
    logic [QM_W-1:0] w_rem;
    logic            w_corr;
    logic [16:0]     w_qc;
    logic [QM_W-1:0] w_rc;
    logic [RW-1:0]   n_n;
    logic [SW-1:0]   n_r;
    logic [SW-1:0]   r_r5;
    // stages 6 to 8
    logic [PU_W-1:0] r_pu6;
    logic [SW-1:0]   r_r6, r_r7;
    logic [15:0]     r_ue7;
    logic [UM_W-1:0] r_um7;
    logic [UM_W-1:0] w_rem2;

    always_comb begin
        w_k32          = 32'(i_kelvin);
        w_under        = w_k32 < 32'(LO);
        w_over         = w_k32 > 32'(HI);
        n_meta.status  = w_under ? ctsi_pkg::ST_UNDER :
                         (w_over ? ctsi_pkg::ST_OVER : ctsi_pkg::ST_IN_RANGE);
        n_meta.used    = w_under ? 16'(LO) : (w_over ? 16'(HI) : i_kelvin);
    end

    always_comb begin
        w_rem  = QM_W'(r_off4) - r_qm4;
        w_corr = w_rem >= QM_W'(STEP_V);
        w_qc   = r_q4 + 17'(w_corr);
        w_rc   = w_corr ? w_rem - QM_W'(STEP_V) : w_rem;
        priority if (r_under4) begin
            n_n = '0;
            n_r = '0;
        end else if (r_over4) begin
            n_n = RW'(TABLE_ROWS - 1);
            n_r = '0;
        end else begin
            n_n = RW'(w_qc);
            n_r = SW'(w_rc);
        end
    end

    assign w_rem2 = {r_r7, 16'h0000} - r_um7;

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_off2   <= 16'(w_k32 - 32'(LO));
            r_under2 <= w_under;
            r_over2  <= w_over;
            o_meta   <= n_meta;
        end
        if (i_en[1]) begin
            r_prod3  <= 49'(r_off2) * 49'(RECIP);
            r_off3   <= r_off2;
            r_under3 <= r_under2;
            r_over3  <= r_over2;
        end
        if (i_en[2]) begin
            r_q4     <= r_prod3[48:32];
            r_qm4    <= QM_W'(r_prod3[48:32]) * QM_W'(STEP_V);
            r_off4   <= r_off3;
            r_under4 <= r_under3;
            r_over4  <= r_over3;
        end
        if (i_en[3]) begin
            o_n          <= n_n;
            r_r5         <= n_r;
            o_seg.first  <= n_n == '0;
            o_seg.m1_end <= 32'(n_n) >= 32'(TABLE_ROWS - 2);
            o_seg.direct <= n_n == RW'(TABLE_ROWS - 1);
        end
        if (i_en[4]) begin
            r_pu6 <= PU_W'(r_r5) * PU_W'(RECIP);
            r_r6  <= r_r5;
        end
        if (i_en[5]) begin
            r_ue7 <= r_pu6[31:16];
            r_um7 <= UM_W'(r_pu6[31:16]) * UM_W'(STEP_V);
            r_r7  <= r_r6;
        end
        if (i_en[6]) begin
            o_u <= r_ue7 + 16'(w_rem2 >= UM_W'(STEP_V));
        end
    end

endmodule

`default_nettype wire

// ----- rtl/ctsi_lane.sv -----
// one channel of the hermite evaluation: tangents, coefficients and horner steps
// depends on ctsi_pkg
`default_nettype none

module ctsi_lane (
    input  wire logic                                  i_clk,
    input  wire logic [8:0]                            i_en,
    input  wire logic [3:0][ctsi_pkg::Y_W-1:0]         i_q,
    input  wire ctsi_pkg::t_lane_ctl                   i_ctl,
    input  wire logic [15:0]                           i_u,
    output logic signed [ctsi_pkg::P_W-1:0]            o_p
);

    localparam int D_W    = ctsi_pkg::D_W;
    localparam int M_W    = ctsi_pkg::M_W;
    localparam int C_W    = ctsi_pkg::C_W;
    localparam int ACC_W  = ctsi_pkg::ACC_W;
    localparam int PROD_W = ctsi_pkg::PROD_W;
    localparam int TOT_W  = ctsi_pkg::TOT_W;
    localparam int P_W    = ctsi_pkg::P_W;
    localparam int Y_W    = ctsi_pkg::Y_W;
    localparam int U_W_C  = ctsi_pkg::U_W;

    logic signed [Y_W-1:0]    w_ym1, w_y0, w_y1, w_y2;
    logic signed [D_W-1:0]    r_dm1, r_d7, r_dp1;
    logic signed [Y_W-1:0]    r_y0 [7:14];
    logic                     r_dir [7:14];
    ctsi_pkg::t_seg           r_seg7;
    logic signed [M_W-1:0]    n_m0, n_m1, r_m0_8, r_m1_8;
    logic signed [D_W-1:0]    r_d8;
    logic signed [C_W-1:0]    w_dc, w_m0c, w_m1c, n_c2, n_c3;
    logic signed [C_W-1:0]    r_c2_9, r_c3_9, r_c2_10;
    logic signed [M_W-1:0]    r_m0 [9:12];
    logic [15:0]              r_u [9:13];
    logic signed [U_W_C-1:0]  w_us10, w_us12, w_us14;
    logic signed [PROD_W-1:0] r_prod10, r_prod12, r_prod14;
    logic signed [ACC_W-1:0]  r_a2, r_a1;
    logic signed [TOT_W-1:0]  w_tot;

    always_comb begin
        w_ym1 = i_q[i_ctl.rot];
        w_y0  = i_q[2'(i_ctl.rot + 2'd1)];
        w_y1  = i_q[2'(i_ctl.rot + 2'd2)];
        w_y2  = i_q[2'(i_ctl.rot + 2'd3)];
    end

    always_comb begin
        n_m0 = r_seg7.first  ? (M_W'(r_d7) <<< 1) : (M_W'(r_dm1) + M_W'(r_d7));
        n_m1 = r_seg7.m1_end ? (M_W'(r_d7) <<< 1) : (M_W'(r_d7) + M_W'(r_dp1));
    end

    always_comb begin
        w_dc  = C_W'(r_d8);
        w_m0c = C_W'(r_m0_8);
        w_m1c = C_W'(r_m1_8);
        n_c2  = (w_dc <<< 2) + (w_dc <<< 1) - (w_m0c <<< 1) - w_m1c;
        n_c3  = w_m0c + w_m1c - (w_dc <<< 2);
    end

    assign w_us10 = $signed({1'b0, r_u[9]});
    assign w_us12 = $signed({1'b0, r_u[11]});
    assign w_us14 = $signed({1'b0, r_u[13]});
    assign w_tot  = (TOT_W'(r_y0[14]) <<< 17) + TOT_W'(r_prod14);

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_dm1     <= D_W'(w_y0) - D_W'(w_ym1);
            r_d7      <= D_W'(w_y1) - D_W'(w_y0);
            r_dp1     <= D_W'(w_y2) - D_W'(w_y1);
            r_y0[7]   <= w_y0;
            r_dir[7]  <= i_ctl.seg.direct;
            r_seg7    <= i_ctl.seg;
        end
        if (i_en[1]) begin
            r_m0_8    <= n_m0;
            r_m1_8    <= n_m1;
            r_d8      <= r_d7;
            r_y0[8]   <= r_y0[7];
            r_dir[8]  <= r_dir[7];
        end
        if (i_en[2]) begin
            r_c2_9    <= n_c2;
            r_c3_9    <= n_c3;
            r_m0[9]   <= r_m0_8;
            r_u[9]    <= i_u;
            r_y0[9]   <= r_y0[8];
            r_dir[9]  <= r_dir[8];
        end
        if (i_en[3]) begin
            r_prod10  <= PROD_W'(r_c3_9) * PROD_W'(w_us10);
            r_c2_10   <= r_c2_9;
            r_m0[10]  <= r_m0[9];
            r_u[10]   <= r_u[9];
            r_y0[10]  <= r_y0[9];
            r_dir[10] <= r_dir[9];
        end
        if (i_en[4]) begin
            r_a2      <= ACC_W'(r_c2_10) + ACC_W'(r_prod10 >>> 16);
            r_m0[11]  <= r_m0[10];
            r_u[11]   <= r_u[10];
            r_y0[11]  <= r_y0[10];
            r_dir[11] <= r_dir[10];
        end
        if (i_en[5]) begin
            r_prod12  <= PROD_W'(r_a2) * PROD_W'(w_us12);
            r_m0[12]  <= r_m0[11];
            r_u[12]   <= r_u[11];
            r_y0[12]  <= r_y0[11];
            r_dir[12] <= r_dir[11];
        end
        if (i_en[6]) begin
            r_a1      <= ACC_W'(r_m0[12]) + ACC_W'(r_prod12 >>> 16);
            r_u[13]   <= r_u[12];
            r_y0[13]  <= r_y0[12];
            r_dir[13] <= r_dir[12];
        end
        if (i_en[7]) begin
            r_prod14  <= PROD_W'(r_a1) * PROD_W'(w_us14);
            r_y0[14]  <= r_y0[13];
            r_dir[14] <= r_dir[13];
        end
        if (i_en[8]) begin
            o_p <= r_dir[14] ? P_W'(r_y0[14]) : P_W'(w_tot >>> 17);
        end
    end

endmodule

`default_nettype wire

// ----- rtl/color_temp_spline_interp.sv -----
// colour temperature spline interpolator, top level
// query result valid from the last stage; one transaction per cycle while the output
// is ready, a load needs no result and leaves the pipeline at the table write stage
// each stage advances when it is empty or the next one advances, so bubbles close up
// synchronous active-low reset clears the stage valid bits only
// tables are 28 interleaved rams (7 channels by 4 row banks), undefined until loaded
`default_nettype none

module color_temp_spline_interp #(
    parameter int TABLE_ROWS        = ctsi_pkg::TABLE_ROWS_DEF,
    parameter int KELVIN_STEP       = ctsi_pkg::KELVIN_STEP_DEF,
    parameter int KELVIN_BASE_STEPS = ctsi_pkg::KELVIN_BASE_STEPS_DEF
) (
    input wire logic  i_clk,
    input wire logic  i_rst_n,
    ctsi_in_if.sink   i_in,
    ctsi_out_if.source o_out
);

    localparam int NS    = ctsi_pkg::NSTAGE;
    localparam int NCH   = ctsi_pkg::NCHAN;
    localparam int Y_W   = ctsi_pkg::Y_W;
    localparam int P_W   = ctsi_pkg::P_W;
    localparam int RW    = $clog2(TABLE_ROWS);
    localparam int DEPTH = (TABLE_ROWS + 3) / 4;
    localparam int AW    = DEPTH > 1 ? $clog2(DEPTH) : 1;
    localparam logic [15:0] LO16 = 16'(KELVIN_BASE_STEPS * KELVIN_STEP);
    localparam logic [15:0] HI16 = 16'((KELVIN_BASE_STEPS + TABLE_ROWS - 1) * KELVIN_STEP);

    logic [NS+1:1]    w_en;
    logic [NS:1]      r_v;
    logic             r_op  [1:5];
    logic [8:0]       r_idx [1:5];
    logic [2:0]       r_ch  [1:5];
    logic [Y_W-1:0]   r_val [1:5];
    logic [15:0]      r_kelvin1;

    ctsi_pkg::t_meta  w_meta2;
    ctsi_pkg::t_meta  r_meta [3:15];
    logic [RW-1:0]    w_n5;
    ctsi_pkg::t_seg   w_seg5;
    logic [15:0]      w_u8;
    ctsi_pkg::t_lane_ctl r_ctl6;

    logic signed [RW+1:0]   w_nm1;
    logic [3:0][AW-1:0]     w_raddr;
    logic [31:0]            w_idx32;
    logic                   w_wr_ok;

    logic [NCH-1:0][3:0][Y_W-1:0] w_q;
    logic signed [P_W-1:0]        w_p [NCH];

    ctsi_pkg::t_meta  r_out_meta;
    logic [31:0]      r_out_int;
    logic [16:0]      r_out_nr, r_out_ng, r_out_nb;
    logic [7:0]       r_out_br, r_out_bg, r_out_bb;

    always_comb begin
        w_en[NS+1] = o_out.ready;
        for (int k = NS; k >= 1; k--) begin
            w_en[k] = !r_v[k] || w_en[k+1];
        end
    end

    assign i_in.ready = w_en[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[1]) begin
                r_v[1] <= i_in.valid;
            end
            for (int k = 2; k <= NS; k++) begin
                if (w_en[k]) begin
                    if (k == 6) begin
                        r_v[k] <= r_v[k-1] && (r_op[5] == ctsi_pkg::OP_QUERY);
                    end else begin
                        r_v[k] <= r_v[k-1];
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r_op[1]   <= i_in.opcode;
            r_idx[1]  <= i_in.entry_index;
            r_ch[1]   <= i_in.channel;
            r_val[1]  <= i_in.value;
            r_kelvin1 <= i_in.kelvin;
        end
        for (int k = 2; k <= 5; k++) begin
            if (w_en[k]) begin
                r_op[k]  <= r_op[k-1];
                r_idx[k] <= r_idx[k-1];
                r_ch[k]  <= r_ch[k-1];
                r_val[k] <= r_val[k-1];
            end
        end
        if (w_en[3]) begin
            r_meta[3] <= w_meta2;
        end
        for (int k = 4; k <= 15; k++) begin
            if (w_en[k]) begin
                r_meta[k] <= r_meta[k-1];
            end
        end
        if (w_en[6]) begin
            r_ctl6.rot <= w_nm1[1:0];
            r_ctl6.seg <= w_seg5;
        end
    end

    ctsi_locate #(
        .TABLE_ROWS        (TABLE_ROWS),
        .KELVIN_STEP       (KELVIN_STEP),
        .KELVIN_BASE_STEPS (KELVIN_BASE_STEPS)
    ) u_locate (
        .i_clk    (i_clk),
        .i_en     (w_en[8:2]),
        .i_kelvin (r_kelvin1),
        .o_meta   (w_meta2),
        .o_n      (w_n5),
        .o_seg    (w_seg5),
        .o_u      (w_u8)
    );

    // rows n-1 .. n+2 fall in four different banks
    assign w_nm1 = $signed({2'b00, w_n5}) - (RW+2)'(1);

    always_comb begin
        for (int b = 0; b < 4; b++) begin
            logic [1:0]           t;
            logic signed [RW+1:0] j;
            t = 2'(b) - w_nm1[1:0];
            j = w_nm1 + $signed((RW+2)'(t));
            if (!j[RW+1] && ($unsigned(j) < (RW+2)'(TABLE_ROWS))) begin
                w_raddr[b] = j[AW+1:2];
            end else begin
                w_raddr[b] = '0;
            end
        end
    end

    assign w_idx32 = 32'(r_idx[5]);
    assign w_wr_ok = r_v[5] && (r_op[5] == ctsi_pkg::OP_LOAD) && w_en[6]
                     && (w_idx32 < 32'(TABLE_ROWS));

    for (genvar c = 0; c < NCH; c++) begin : g_chan
        for (genvar b = 0; b < 4; b++) begin : g_bank
            ctsi_ram #(
                .WIDTH (Y_W),
                .DEPTH (DEPTH)
            ) u_ram (
                .i_clk   (i_clk),
                .i_we    (w_wr_ok && (r_ch[5] == 3'(c)) && (w_idx32[1:0] == 2'(b))),
                .i_waddr (w_idx32[AW+1:2]),
                .i_wdata (r_val[5]),
                .i_re    (w_en[6]),
                .i_raddr (w_raddr[b]),
                .o_rdata (w_q[c][b])
            );
        end

        ctsi_lane u_lane (
            .i_clk (i_clk),
            .i_en  (w_en[15:7]),
            .i_q   (w_q[c]),
            .i_ctl (r_ctl6),
            .i_u   (w_u8),
            .o_p   (w_p[c])
        );
    end

    always_ff @(posedge i_clk) begin
        if (w_en[16]) begin
            r_out_meta <= r_meta[15];
            r_out_int  <= ctsi_pkg::sat_int(w_p[ctsi_pkg::CH_INTENSITY]);
            r_out_nr   <= ctsi_pkg::clamp_norm(w_p[ctsi_pkg::CH_NORM_R]);
            r_out_ng   <= ctsi_pkg::clamp_norm(w_p[ctsi_pkg::CH_NORM_G]);
            r_out_nb   <= ctsi_pkg::clamp_norm(w_p[ctsi_pkg::CH_NORM_B]);
            r_out_br   <= ctsi_pkg::to_byte(w_p[ctsi_pkg::CH_BYTE_R]);
            r_out_bg   <= ctsi_pkg::to_byte(w_p[ctsi_pkg::CH_BYTE_G]);
            r_out_bb   <= ctsi_pkg::to_byte(w_p[ctsi_pkg::CH_BYTE_B]);
        end
    end

    assign o_out.valid       = r_v[NS];
    assign o_out.status      = r_out_meta.status;
    assign o_out.kelvin_used = r_out_meta.used;
    assign o_out.intensity   = r_out_int;
    assign o_out.lvl_red     = r_out_nr;
    assign o_out.lvl_green   = r_out_ng;
    assign o_out.lvl_blue    = r_out_nb;
    assign o_out.pwm_red     = r_out_br;
    assign o_out.pwm_green   = r_out_bg;
    assign o_out.pwm_blue    = r_out_bb;

    a_under_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && (o_out.status == ctsi_pkg::ST_UNDER) |-> o_out.kelvin_used == LO16)
        else $error("under-range result with wrong kelvin_used");

    a_over_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && (o_out.status == ctsi_pkg::ST_OVER) |-> o_out.kelvin_used == HI16)
        else $error("over-range result with wrong kelvin_used");

    a_norm_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.lvl_red <= 17'd65536) && (o_out.lvl_green <= 17'd65536)
                        && (o_out.lvl_blue <= 17'd65536))
        else $error("normalised channel outside clamp");

    a_no_load_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[5] && (r_op[5] == ctsi_pkg::OP_LOAD) && w_en[6] |=> !r_v[6])
        else $error("load transaction carried past the table write stage");

endmodule

`default_nettype wire

// ----- test/tb_top.sv -----
// self-checking testbench for the colour temperature spline interpolator
// depends on ctsi_pkg, ctsi_in_if, ctsi_out_if and color_temp_spline_interp from the rtl folder
// loads the low and high end windows of every table, then checks queries inside them
`default_nettype none

module tb_top;

    localparam int NCH    = ctsi_pkg::NCHAN;
    localparam int ROWS   = ctsi_pkg::TABLE_ROWS_DEF;
    localparam int STEP   = ctsi_pkg::KELVIN_STEP_DEF;
    localparam int K_LO   = ctsi_pkg::KELVIN_BASE_STEPS_DEF * STEP;
    localparam int K_HI   = (ctsi_pkg::KELVIN_BASE_STEPS_DEF + ROWS - 1) * STEP;
    localparam int WIN    = 12;
    localparam int K_LOW_TOP  = K_LO + (WIN - 2) * STEP - 1;
    localparam int K_HIGH_BOT = K_HI - (WIN - 2) * STEP;
    localparam int LATENCY = 16;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        logic [1:0]  status;
        logic [15:0] used;
        logic [31:0] inten;
        logic [16:0] nr, ng, nb;
        logic [7:0]  br, bg, bb;
    } t_colour;

    typedef struct {
        ctsi_pkg::t_opcode op;
        logic [8:0]  idx;
        logic [2:0]  ch;
        logic [31:0] val;
        logic [15:0] k;
        logic        typed;
        t_colour     want;
    } t_stim;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    ctsi_in_if  in_ch();
    ctsi_out_if out_ch();

    color_temp_spline_interp uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    longint  sample_table [NCH][ROWS];
    t_colour colour_queue [$];
    int      errors = 0;
    int      cycles = 0;
    int      queries_done = 0;
    int      loads_done = 0;
    int      send_idle_pct = 12;
    int      recv_idle_pct = 49;
    t_stim   directed [$];

    function automatic longint floor_sh(longint x);
        return x >>> 16;
    endfunction

    function automatic longint slope2(int c, int i);
        if (i == 0) return 2 * (sample_table[c][1] - sample_table[c][0]);
        if (i >= ROWS - 1) return 2 * (sample_table[c][ROWS-1] - sample_table[c][ROWS-2]);
        return sample_table[c][i+1] - sample_table[c][i-1];
    endfunction

    function automatic longint hermite(int c, int n, longint u);
        longint d, m0, m1, c2, c3, a2, a1;
        if (n >= ROWS - 1) return sample_table[c][ROWS-1];
        d  = sample_table[c][n+1] - sample_table[c][n];
        m0 = slope2(c, n);
        m1 = slope2(c, n + 1);
        c2 = 6 * d - 2 * m0 - m1;
        c3 = m0 + m1 - 4 * d;
        a2 = c2 + floor_sh(c3 * u);
        a1 = m0 + floor_sh(a2 * u);
        return (2 * sample_table[c][n] * 65536 + a1 * u) >>> 17;
    endfunction

    function automatic logic [16:0] norm_of(longint p);
        return p < 0 ? 17'd0 : (p > 65536 ? 17'd65536 : 17'(p));
    endfunction

    function automatic logic [7:0] byte_of(longint p);
        longint cl, ip, fr;
        cl = p < 0 ? 0 : (p > 255 * 65536 ? 255 * 65536 : p);
        ip = cl >> 16;
        fr = cl & 16'hffff;
        if (fr > 32768 || (fr == 32768 && ip[0])) ip++;
        return 8'(ip);
    endfunction

    function automatic t_colour predict_colour(logic [15:0] k);
        t_colour r;
        int n;
        longint u, p[NCH];
        u = 0;
        if (k < K_LO) begin
            r.status = ctsi_pkg::ST_UNDER; r.used = 16'(K_LO); n = 0;
        end else if (k > K_HI) begin
            r.status = ctsi_pkg::ST_OVER; r.used = 16'(K_HI); n = ROWS - 1;
        end else begin
            r.status = ctsi_pkg::ST_IN_RANGE; r.used = k;
            n = (k - K_LO) / STEP;
            u = (((k - K_LO) % STEP) * 65536) / STEP;
        end
        for (int c = 0; c < NCH; c++) p[c] = hermite(c, n, u);
        r.inten = p[0] > 64'sd2147483647 ? 32'h7fff_ffff :
                  p[0] < -64'sd2147483648 ? 32'h8000_0000 : 32'(p[0]);
        r.nr = norm_of(p[1]); r.ng = norm_of(p[2]); r.nb = norm_of(p[3]);
        r.br = byte_of(p[4]); r.bg = byte_of(p[5]); r.bb = byte_of(p[6]);
        return r;
    endfunction

    // valid stays high between back-to-back transactions
    task automatic send_item(ctsi_pkg::t_opcode op, logic [8:0] idx, logic [2:0] ch,
                             logic [31:0] val, logic [15:0] k);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.opcode      <= op;
        in_ch.entry_index <= idx;
        in_ch.channel     <= ch;
        in_ch.value       <= val;
        in_ch.kelvin      <= k;
        do @(posedge i_clk); while (!in_ch.ready);
        if (op == ctsi_pkg::OP_LOAD) begin
            if (idx < ROWS && ch < NCH) sample_table[ch][idx] = longint'($signed(val));
            loads_done++;
        end else begin
            colour_queue.push_back(predict_colour(k));
        end
        @(negedge i_clk);
    endtask

    task automatic load_row(int idx, logic [31:0] val, int ch);
        send_item(ctsi_pkg::OP_LOAD, 9'(idx), 3'(ch), val, 16'($urandom));
    endtask

    task automatic query(logic [15:0] k);
        send_item(ctsi_pkg::OP_QUERY, 9'($urandom), 3'($urandom), $urandom, k);
    endtask

    function automatic logic [31:0] rand_sample(int ch);
        case ($urandom_range(3))
            0: return $urandom;
            1: return ch == 0 ? $urandom : $urandom_range(300 * 65536);
            2: return $urandom_range(70000) - 2000;
            default: return ch >= 4 ? $urandom_range(256 * 65536) : $urandom_range(65536);
        endcase
    endfunction

    // a row inside the loaded low or high window
    function automatic int win_row();
        int r;
        r = $urandom_range(WIN - 1);
        if ($urandom_range(1) != 0) r = ROWS - WIN + r;
        return r;
    endfunction

    // a temperature whose spline only touches loaded rows
    function automatic logic [15:0] win_kelvin();
        if ($urandom_range(1) != 0) return 16'($urandom_range(K_LOW_TOP, K_LO));
        return 16'($urandom_range(K_HI, K_HIGH_BOT));
    endfunction

    task automatic fill_windows(logic mid);
        for (int c = 0; c < NCH; c++)
            for (int i = 0; i < WIN; i++) begin
                load_row(i, mid ? 32'h0000_8000 : rand_sample(c), c);
                load_row(ROWS - WIN + i, mid ? 32'h0000_8000 : rand_sample(c), c);
            end
    endtask

    always @(negedge i_clk) out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);

    always @(posedge i_clk) begin
        t_colour w;
        cycles <= cycles + 1;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (colour_queue.size() == 0) begin
                $display("%0t: unexpected result status=%0d", $time, out_ch.status);
                errors++;
            end else begin
                w = colour_queue.pop_front();
                queries_done++;
                if (w.status !== out_ch.status || w.used !== out_ch.kelvin_used ||
                    w.inten !== out_ch.intensity || w.nr !== out_ch.lvl_red ||
                    w.ng !== out_ch.lvl_green || w.nb !== out_ch.lvl_blue ||
                    w.br !== out_ch.pwm_red || w.bg !== out_ch.pwm_green ||
                    w.bb !== out_ch.pwm_blue) begin
                    $display("%0t: mismatch expected st=%0d k=%0d i=%h n=%h/%h/%h b=%h/%h/%h",
                             $time, w.status, w.used, w.inten, w.nr, w.ng, w.nb,
                             w.br, w.bg, w.bb);
                    $display("%0t:          actual st=%0d k=%0d i=%h n=%h/%h/%h b=%h/%h/%h",
                             $time, out_ch.status, out_ch.kelvin_used, out_ch.intensity,
                             out_ch.lvl_red, out_ch.lvl_green, out_ch.lvl_blue,
                             out_ch.pwm_red, out_ch.pwm_green, out_ch.pwm_blue);
                    errors++;
                end
            end
        end
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout with %0d results outstanding", colour_queue.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic run_directed();
        t_stim s;
        t_colour ends;
        // window rows at mid scale so end rows are easy to read off
        fill_windows(1'b1);
        ends = '{ctsi_pkg::ST_UNDER, 16'(K_LO), 32'h8000, 17'h8000, 17'h8000, 17'h8000,
                 0, 0, 0};
        s = '{ctsi_pkg::OP_QUERY, 0, 0, 0, 16'd0, 1'b1, ends};
        directed.push_back(s);
        s.k = 16'(K_LO - 1); directed.push_back(s);
        ends.status = ctsi_pkg::ST_OVER; ends.used = 16'(K_HI);
        s.k = 16'hffff; s.want = ends; directed.push_back(s);
        s.k = 16'(K_HI + 1); directed.push_back(s);
        ends.status = ctsi_pkg::ST_IN_RANGE;
        s.k = 16'(K_HI); s.want = ends; directed.push_back(s);
        s.typed = 1'b0;
        // extreme samples, an ignored load, then spline points
        s = '{ctsi_pkg::OP_LOAD, 9'd0, ctsi_pkg::CH_INTENSITY, 32'h7fff_ffff, 16'hffff,
              1'b0, ends};
        directed.push_back(s);
        s.idx = 9'd1; s.val = 32'h8000_0000; directed.push_back(s);
        s.idx = 9'd2; s.ch = ctsi_pkg::CH_NORM_R; s.val = 32'hffff_ffff; directed.push_back(s);
        s.idx = 9'd1; s.val = 32'h0002_0000; directed.push_back(s);
        s.idx = 9'd3; s.ch = ctsi_pkg::CH_BYTE_R; s.val = 32'h0100_0000; directed.push_back(s);
        s.idx = 9'd4; s.ch = ctsi_pkg::CH_BYTE_G; s.val = 32'h0002_8000; directed.push_back(s);
        s.idx = 9'd5; s.val = 32'h0003_8000; directed.push_back(s);
        s.idx = 9'd511; s.ch = ctsi_pkg::CH_BYTE_B; s.val = 32'h0000_0000;
        directed.push_back(s);
        s.idx = 9'd7; s.ch = 3'd7; s.val = 32'h1234_5678; directed.push_back(s);
        s.op = ctsi_pkg::OP_QUERY;
        for (int k = K_LO; k <= K_LO + 600; k += 50) begin
            s.k = 16'(k); directed.push_back(s);
        end
        s.k = 16'(K_HI - 1); directed.push_back(s);
        foreach (directed[j]) begin
            if (directed[j].typed) begin
                query(directed[j].k);
                colour_queue[$] = directed[j].want;
            end else begin
                send_item(directed[j].op, directed[j].idx, directed[j].ch,
                          directed[j].val, directed[j].k);
            end
        end
    endtask

    task automatic run_random(int count);
        for (int j = 0; j < count; j++) begin
            int c;
            int ch;
            c  = $urandom_range(99);
            ch = $urandom_range(NCH - 1);
            if (c < 35) load_row(win_row(), rand_sample(ch), ch);
            else if (c < 37) send_item(ctsi_pkg::OP_LOAD, 9'($urandom), 3'd7, $urandom,
                                       16'($urandom));
            else if (c < 85) query(win_kelvin());
            else if (c < 90) query(16'($urandom_range(K_LO + 300, K_LO)));
            else if (c < 95) query(16'($urandom_range(K_HI, K_HI - 300)));
            else if (c < 97) query(16'($urandom_range(K_LO - 1)));
            else query(16'($urandom_range(16'hffff, K_HI + 1)));
        end
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (colour_queue.size() != 0) @(negedge i_clk);
        repeat (LATENCY + 4) @(negedge i_clk);
    endtask

    initial begin
        in_ch.valid = 1'b0; in_ch.opcode = ctsi_pkg::OP_LOAD; in_ch.entry_index = '0;
        in_ch.channel = '0; in_ch.value = '0; in_ch.kelvin = '0;
        out_ch.ready = 1'b0;
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;
        run_directed();
        // random window samples over the full range
        fill_windows(1'b0);
        run_random(180);
        drain();
        send_idle_pct = 49; recv_idle_pct = 12;
        run_random(180);
        send_idle_pct = 0; recv_idle_pct = 0;
        run_random(180);
        drain();
        $display("%0d loads and %0d queries checked across under, over and in range",
                 loads_done, queries_done);
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule

`default_nettype wire
